// ----- hdl/cpr_pkg.sv -----
// Shared constants and controller/datapath interface types for the clock
// page replacement block. No dependencies.

package cpr_pkg;

   localparam int SLOTS_DEFAULT     = 128;
   localparam int PAGE_BITS_DEFAULT = 8;

   // capacity register
   localparam int            CAPACITY_W     = 8;
   localparam logic [7:0]    CAPACITY_RESET = 8'd128;

   // controller -> datapath
   typedef struct packed {
      logic start;      // latch page, restart the search
      logic scan;       // read next filled slot
      logic hit;        // match found: set use bit, stage hit result
      logic fill;       // miss with free slot: write next slot
      logic sweep;      // clear use bit at hand, advance hand
      logic evict_rd;   // read victim page at hand
      logic evict_wr;   // overwrite victim, stage eviction result
      logic out_load;   // move staged result to output register
   } cpr_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic match;       // compared slot holds the page
      logic scan_more;   // filled slots left to read
      logic full;        // filled count has reached capacity
      logic use_at_hand; // use bit under the hand is set
   } cpr_status_type;

endpackage

// ----- hdl/cpr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module cpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/cpr_ctrl.sv -----
// Sequencing state machine for the clock page replacement block.
// Depends on cpr_pkg.

module cpr_ctrl import cpr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic           csr_ready,
   input  cpr_status_type status,
   output cpr_cmd_type    cmd
);

   typedef enum logic [2:0] {
      IDLE,
      SCAN,
      SWEEP,
      EVICT,
      RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = SCAN;
            end
         end
         SCAN: begin
            if (status.match) begin
               cmd.hit  = 1'b1;
               state_in = RESULT;
            end else if (status.scan_more) begin
               cmd.scan = 1'b1;
            end else if (!status.full) begin
               cmd.fill = 1'b1;
               state_in = RESULT;
            end else begin
               state_in = SWEEP;
            end
         end
         SWEEP: begin
            if (status.use_at_hand) begin
               cmd.sweep = 1'b1;
            end else begin
               cmd.evict_rd = 1'b1;
               state_in     = EVICT;
            end
         end
         EVICT: begin
            cmd.evict_wr = 1'b1;
            state_in     = RESULT;
         end
         RESULT: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != IDLE);
   assign csr_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hdl/cpr_datapath.sv -----
// Datapath: page RAM, use bits, fill count, clock hand, capacity and
// result registers. Depends on cpr_pkg and cpr_ram.

module cpr_datapath import cpr_pkg::*; #(
   parameter int SLOTS     = SLOTS_DEFAULT,
   parameter int PAGE_BITS = PAGE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cfg_we,
   input  logic [CAPACITY_W-1:0]    cfg_capacity,
   input  logic [PAGE_BITS-1:0]     page_number,
   input  cpr_cmd_type              cmd,
   output cpr_status_type           status,
   output logic                     out_hit,
   output logic [$clog2(SLOTS)-1:0] out_slot,
   output logic                     out_evicted_valid,
   output logic [PAGE_BITS-1:0]     out_evicted_page
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int CAP_W  = (CNT_W > CAPACITY_W) ? CNT_W : CAPACITY_W;

   logic [CNT_W-1:0]     cap_ff, cap_in;
   logic [CNT_W-1:0]     filled_ff;
   logic [SLOT_W-1:0]    hand_ff;
   logic [SLOTS-1:0]     use_ff;
   logic [PAGE_BITS-1:0] page_ff;
   logic [CNT_W-1:0]     scan_addr_ff;
   logic [SLOT_W-1:0]    cmp_idx_ff;
   logic                 cmp_valid_ff;

   logic                 res_hit_ff, res_ev_valid_ff;
   logic [SLOT_W-1:0]    res_slot_ff;
   logic [PAGE_BITS-1:0] res_ev_page_ff;

   logic                 rsp_hit_ff, rsp_ev_valid_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic [PAGE_BITS-1:0] rsp_ev_page_ff;

   logic [CAP_W-1:0]     cap_raw;
   logic [CNT_W-1:0]     hand_next;
   logic [SLOT_W-1:0]    fill_idx;
   logic                 ram_we, ram_re;
   logic [SLOT_W-1:0]    ram_waddr, ram_raddr;
   logic [PAGE_BITS-1:0] ram_rdata;

   // clamp capacity to 1..SLOTS
   always_comb begin
      cap_raw = reset ? CAP_W'(CAPACITY_RESET) : CAP_W'(cfg_capacity);
      if (cap_raw == '0) begin
         cap_in = CNT_W'(1);
      end else if (cap_raw > CAP_W'(SLOTS)) begin
         cap_in = CNT_W'(SLOTS);
      end else begin
         cap_in = CNT_W'(cap_raw);
      end
   end

   assign fill_idx  = filled_ff[SLOT_W-1:0];
   assign hand_next = CNT_W'(hand_ff) + CNT_W'(1);

   assign ram_we    = cmd.fill | cmd.evict_wr;
   assign ram_waddr = cmd.fill ? fill_idx : hand_ff;
   assign ram_re    = cmd.scan | cmd.evict_rd;
   assign ram_raddr = cmd.evict_rd ? hand_ff : scan_addr_ff[SLOT_W-1:0];

   cpr_ram #(
      .WIDTH (PAGE_BITS),
      .DEPTH (SLOTS)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (page_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign status.match       = cmp_valid_ff && (ram_rdata == page_ff);
   assign status.scan_more   = (scan_addr_ff < filled_ff);
   assign status.full        = (filled_ff == cap_ff);
   assign status.use_at_hand = use_ff[hand_ff];

   // control state
   always_ff @(posedge clock) begin
      if (reset || cfg_we) begin
         cap_ff    <= cap_in;
         filled_ff <= '0;
         hand_ff   <= '0;
         use_ff    <= '0;
      end else begin
         if (cmd.hit) begin
            use_ff[cmp_idx_ff] <= 1'b1;
         end
         if (cmd.fill) begin
            use_ff[fill_idx] <= 1'b1;
            filled_ff        <= filled_ff + CNT_W'(1);
         end
         if (cmd.sweep) begin
            use_ff[hand_ff] <= 1'b0;
            hand_ff         <= (hand_next >= cap_ff) ? '0 : hand_next[SLOT_W-1:0];
         end
         if (cmd.evict_wr) begin
            use_ff[hand_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
      end else if (cmd.start) begin
         cmp_valid_ff <= 1'b0;
      end else if (cmd.scan) begin
         cmp_valid_ff <= 1'b1;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         page_ff      <= page_number;
         scan_addr_ff <= '0;
      end
      if (cmd.scan) begin
         cmp_idx_ff   <= scan_addr_ff[SLOT_W-1:0];
         scan_addr_ff <= scan_addr_ff + CNT_W'(1);
      end
      if (cmd.hit) begin
         res_hit_ff      <= 1'b1;
         res_slot_ff     <= cmp_idx_ff;
         res_ev_valid_ff <= 1'b0;
         res_ev_page_ff  <= '0;
      end
      if (cmd.fill) begin
         res_hit_ff      <= 1'b0;
         res_slot_ff     <= fill_idx;
         res_ev_valid_ff <= 1'b0;
         res_ev_page_ff  <= '0;
      end
      if (cmd.evict_wr) begin
         res_hit_ff      <= 1'b0;
         res_slot_ff     <= hand_ff;
         res_ev_valid_ff <= 1'b1;
         res_ev_page_ff  <= ram_rdata;
      end
      if (cmd.out_load) begin
         rsp_hit_ff      <= res_hit_ff;
         rsp_slot_ff     <= res_slot_ff;
         rsp_ev_valid_ff <= res_ev_valid_ff;
         rsp_ev_page_ff  <= res_ev_page_ff;
      end
   end

   assign out_hit           = rsp_hit_ff;
   assign out_slot          = rsp_slot_ff;
   assign out_evicted_valid = rsp_ev_valid_ff;
   assign out_evicted_page  = rsp_ev_page_ff;

endmodule

// ----- hdl/clock_page_replacement.sv -----
// Top level of the clock (second-chance) page replacement store.
// Depends on cpr_pkg, cpr_ctrl, cpr_datapath and cpr_ram.

// One page reference per req transaction, one rsp transaction per reference,
// in order. Pages sit in a single-port-read RAM, so the lookup reads filled
// slots one per cycle starting at slot 0. A hit or a miss with free slots
// then loads the result register. A miss on a full store reads every filled
// slot, then sweeps the clock hand one slot per cycle (clearing set use bits,
// at most capacity of them), then reads the victim and overwrites it. The next
// reference is accepted in the cycle after the result is loaded. The scan
// over the page RAM and the hand sweep set the rate. One reference is in
// flight at a time; a finished result waits in the rsp output register, so
// the next reference is accepted while the previous result is still stalled.
// A csr transaction writes the capacity (0 acts as 1, above SLOTS acts as
// SLOTS) and empties the store; csr_ready is high whenever no reference is
// being worked on. After reset capacity is 128 (clamped to SLOTS) and the
// store is empty; no clearing pass is needed.

module clock_page_replacement import cpr_pkg::*; #(
   parameter int SLOTS     = SLOTS_DEFAULT,
   parameter int PAGE_BITS = PAGE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   // reference channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [PAGE_BITS-1:0]     req_page_number,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_hit,
   output logic [$clog2(SLOTS)-1:0] rsp_slot,
   output logic                     rsp_evicted_valid,
   output logic [PAGE_BITS-1:0]     rsp_evicted_page,
   // capacity register write
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CAPACITY_W-1:0]    csr_capacity
);

   cpr_cmd_type    cmd;
   cpr_status_type status;
   logic           cfg_we;

   // capacity write completes on valid and ready
   assign cfg_we = csr_valid & csr_ready;

   cpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cpr_datapath #(
      .SLOTS     (SLOTS),
      .PAGE_BITS (PAGE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cfg_we            (cfg_we),
      .cfg_capacity      (csr_capacity),
      .page_number       (req_page_number),
      .cmd               (cmd),
      .status            (status),
      .out_hit           (rsp_hit),
      .out_slot          (rsp_slot),
      .out_evicted_valid (rsp_evicted_valid),
      .out_evicted_page  (rsp_evicted_page)
   );

endmodule
